// ===== design/sdnc_pkg.sv =====
// Shared widths, field packing and the interval and note tables of the scale-degree controller.
package sdnc_pkg;

  localparam int unsigned OctW  = 3;
  localparam int unsigned RootW = 4;
  localparam int unsigned ModeW = 3;
  localparam int unsigned PosW  = 2;
  localparam int unsigned FreqW = 11;
  localparam int unsigned KeyW  = 8;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  localparam logic [OctW-1:0]  OctaveTop  = 3'd5;
  localparam logic [RootW-1:0] RootReset  = 4'd8;
  localparam logic [ModeW-1:0] ModeReset  = 3'd5;
  localparam logic [4:0]       NotesOct   = 5'd12;
  localparam logic [ModeW-1:0] ModeLast   = 3'd6;

  // Bit positions of the buttons in the key vector.
  localparam int unsigned KeyA      = 0;
  localparam int unsigned KeyB      = 1;
  localparam int unsigned KeySelect = 2;
  localparam int unsigned KeyStart  = 3;
  localparam int unsigned KeyUp     = 4;
  localparam int unsigned KeyDown   = 5;
  localparam int unsigned KeyLeft   = 6;
  localparam int unsigned KeyRight  = 7;

  // Semitone offset of a scale degree in a given mode.
  function automatic logic [3:0] interval_lut(input logic [2:0] mode, input logic [2:0] deg);
    logic [31:0] row;
    begin
      case (mode)
        3'd0:    row = 32'hC_B_9_7_5_4_2_0;
        3'd1:    row = 32'hC_A_9_7_5_3_2_0;
        3'd2:    row = 32'hC_A_8_7_5_3_1_0;
        3'd3:    row = 32'hC_B_9_7_6_4_2_0;
        3'd4:    row = 32'hC_A_9_7_5_4_2_0;
        3'd5:    row = 32'hC_A_8_7_5_3_2_0;
        3'd6:    row = 32'hC_A_8_6_5_3_1_0;
        default: row = 32'h0;
      endcase
      interval_lut = row[{deg, 2'b00} +: 4];
    end
  endfunction

  // Tone register code for a note within an octave.
  function automatic logic [10:0] freq_lut(input logic [3:0] note, input logic [2:0] oct);
    logic [10:0] c0, c1, c2, c3, c4, c5, c6;
    logic [10:0] res;
    begin
      case (note)
        4'd0: begin
          c0=11'h02C; c1=11'h416; c2=11'h60B; c3=11'h706; c4=11'h782; c5=11'h7C1;
          c6=11'h7E0;
        end
        4'd1: begin
          c0=11'h09D; c1=11'h44E; c2=11'h627; c3=11'h714; c4=11'h789; c5=11'h7C4;
          c6=11'h7E2;
        end
        4'd2: begin
          c0=11'h107; c1=11'h483; c2=11'h642; c3=11'h721; c4=11'h790; c5=11'h7C8;
          c6=11'h7E4;
        end
        4'd3: begin
          c0=11'h16B; c1=11'h4B5; c2=11'h65B; c3=11'h72D; c4=11'h796; c5=11'h7CB;
          c6=11'h7E5;
        end
        4'd4: begin
          c0=11'h1CA; c1=11'h4E5; c2=11'h672; c3=11'h739; c4=11'h79C; c5=11'h7CE;
          c6=11'h7E7;
        end
        4'd5: begin
          c0=11'h223; c1=11'h511; c2=11'h689; c3=11'h744; c4=11'h7A2; c5=11'h7D1;
          c6=11'h7E8;
        end
        4'd6: begin
          c0=11'h277; c1=11'h53C; c2=11'h69E; c3=11'h74F; c4=11'h7A7; c5=11'h7D3;
          c6=11'h7E9;
        end
        4'd7: begin
          c0=11'h2C7; c1=11'h563; c2=11'h6B2; c3=11'h759; c4=11'h7AC; c5=11'h7D6;
          c6=11'h7EB;
        end
        4'd8: begin
          c0=11'h312; c1=11'h589; c2=11'h6C4; c3=11'h762; c4=11'h7B1; c5=11'h7D8;
          c6=11'h7EC;
        end
        4'd9: begin
          c0=11'h358; c1=11'h5AC; c2=11'h6D6; c3=11'h76B; c4=11'h7B5; c5=11'h7DA;
          c6=11'h7ED;
        end
        4'd10: begin
          c0=11'h39B; c1=11'h5CE; c2=11'h6E7; c3=11'h773; c4=11'h7B9; c5=11'h7DC;
          c6=11'h7EE;
        end
        4'd11: begin
          c0=11'h3DA; c1=11'h5ED; c2=11'h6F7; c3=11'h77B; c4=11'h7BD; c5=11'h7DE;
          c6=11'h7EF;
        end
        default: begin
          c0='0; c1='0; c2='0; c3='0; c4='0; c5='0; c6='0;
        end
      endcase
      case (oct)
        3'd0:    res = c0;
        3'd1:    res = c1;
        3'd2:    res = c2;
        3'd3:    res = c3;
        3'd4:    res = c4;
        3'd5:    res = c5;
        3'd6:    res = c6;
        default: res = '0;
      endcase
      freq_lut = res;
    end
  endfunction

endpackage

// ===== design/sdnc_lookup.sv =====
// Scale-degree lookup: interval table, octave carry with clamping and note table.
module sdnc_lookup import sdnc_pkg::*; (
  input  logic [RootW-1:0] root_i,
  input  logic [ModeW-1:0] mode_i,
  input  logic [OctW-1:0]  octave_i,
  input  logic [2:0]       degree_i,
  output logic [FreqW-1:0] freq_o
);

  logic [4:0]      sum;
  logic            carry;
  logic [3:0]      note;
  logic [OctW:0]   oct_sum;
  logic [OctW-1:0] oct_play;

  always_comb begin
    sum   = {1'b0, root_i} + {1'b0, interval_lut(mode_i, degree_i)};
    carry = (sum >= NotesOct);
    note  = carry ? 4'(sum - NotesOct) : sum[3:0];
    // Past the top octave the note is played in the top octave.
    oct_sum  = {1'b0, octave_i} + {{OctW{1'b0}}, carry};
    oct_play = (oct_sum > {1'b0, OctaveTop}) ? OctaveTop : oct_sum[OctW-1:0];
    freq_o   = freq_lut(note, oct_play);
  end

endmodule

// ===== design/scale_degree_note_controller.sv =====
// Top level of the scale-degree note controller: key edge logic, state and result register.
//
// The block takes one item per video frame on the slave stream: the levels of eight
// buttons. For each item it returns exactly one result item on the master stream,
// carrying a tone trigger or silence flag, the 11-bit frequency code of the picked
// scale degree and the octave, root and mode after this frame's update.
//
// All of the work for an item is done by shallow combinational logic between the
// accepted item and the result register, so the result is registered at the
// accepting edge, and one item can be accepted in every cycle while the receiver
// keeps taking results. The result register decouples the two sides: a new item
// is accepted while the held result is being taken in the same cycle, so a waiting
// receiver costs no throughput unless it actually stalls.
//
// When the receiver stalls, the result is held and s_axis_tready stays low until
// it is taken, so nothing is lost or repeated. Reset clears the previous key
// levels, octave, position and sounding flag, sets the root to A flat and the mode
// to Aeolian, and empties the result register.
module scale_degree_note_controller import sdnc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // key_a, key_b, key_select, key_start, key_up, key_down, key_left_shoulder,
  // key_right_shoulder, bits 0 to 7.
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // note_start [0], note_stop [1], freq_code [12:2], octave_now [15:13],
  // root_now [19:16], mode_now [22:20], zero [23].
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic [KeyW-1:0]     prev_q, prev_d;
  logic [OctW-1:0]     octave_q, octave_d;
  logic [RootW-1:0]    root_q, root_d;
  logic [ModeW-1:0]    mode_q, mode_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic                sounding_q, sounding_d;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic [KeyW-1:0]  keys, hit;
  logic             key_a, key_b, sel, st;
  logic             note_start, note_stop;
  logic [4:0]       root_sum;
  logic [RootW-1:0] root_step;
  logic             root_move;
  logic [2:0]       degree;
  logic [FreqW-1:0] freq_lookup, freq_code;
  logic             accept;

  // Take a new item whenever the result register is empty or being emptied.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign keys  = s_axis_tdata;
  assign hit   = keys & ~prev_q;
  assign key_a = keys[KeyA];
  assign key_b = keys[KeyB];
  assign sel   = keys[KeySelect];
  assign st    = keys[KeyStart];

  always_comb begin
    // Octave: up wins over down unless already at the top, both stop at the limits.
    octave_d = octave_q;
    if (hit[KeyUp] && octave_q < OctaveTop) begin
      octave_d = octave_q + 3'd1;
    end else if (hit[KeyDown] && octave_q != '0) begin
      octave_d = octave_q - 3'd1;
    end

    // Root: with start alone a fifth down or up, with start and select a semitone.
    root_step = '0;
    root_move = 1'b0;
    if (st && hit[KeyLeft]) begin
      root_step = sel ? 4'd11 : 4'd5;
      root_move = 1'b1;
    end else if (st && hit[KeyRight]) begin
      root_step = sel ? 4'd1 : 4'd7;
      root_move = 1'b1;
    end
    root_sum = {1'b0, root_q} + {1'b0, root_step};
    root_d   = root_q;
    if (root_move) begin
      root_d = (root_sum >= NotesOct) ? 4'(root_sum - NotesOct) : root_sum[3:0];
    end

    // Mode: with select alone, step down or up through the seven modes.
    mode_d = mode_q;
    if (sel && !st && hit[KeyLeft]) begin
      mode_d = (mode_q == '0) ? ModeLast : mode_q - 3'd1;
    end else if (sel && !st && hit[KeyRight]) begin
      mode_d = (mode_q >= ModeLast) ? '0 : mode_q + 3'd1;
    end

    // Silence once both A and B are released.
    note_stop  = !key_a && !key_b && sounding_q;
    sounding_d = sounding_q && !note_stop;

    pos_d = pos_q;
    if (!st && !sel) begin
      pos_d = {keys[KeyRight], keys[KeyLeft]};
    end

    // B picks the odd degree of the pair, A the even one.
    degree     = {pos_d, ~key_b};
    note_start = !sounding_d && (key_a || key_b);
    if (note_start) begin
      sounding_d = 1'b1;
    end
    freq_code = note_start ? freq_lookup : '0;

    prev_d     = keys;
    out_data_d = {1'b0, mode_d, root_d, octave_d, freq_code, note_stop, note_start};
  end

  sdnc_lookup u_lookup (
    .root_i   (root_d),
    .mode_i   (mode_d),
    .octave_i (octave_d),
    .degree_i (degree),
    .freq_o   (freq_lookup)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      octave_q    <= '0;
      root_q      <= RootReset;
      mode_q      <= ModeReset;
      pos_q       <= '0;
      sounding_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        prev_q      <= prev_d;
        octave_q    <= octave_d;
        root_q      <= root_d;
        mode_q      <= mode_d;
        pos_q       <= pos_d;
        sounding_q  <= sounding_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the scale-degree note controller over its item streams.
`timescale 1ns / 1ps

module tb;
  import sdnc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomItems = 1350;
  localparam int unsigned LongHold = 300;

  // Single-button masks in the key vector.
  localparam logic [7:0] BtnA = 8'(1 << KeyA);
  localparam logic [7:0] BtnB = 8'(1 << KeyB);
  localparam logic [7:0] BtnSel = 8'(1 << KeySelect);
  localparam logic [7:0] BtnStart = 8'(1 << KeyStart);
  localparam logic [7:0] BtnUp = 8'(1 << KeyUp);
  localparam logic [7:0] BtnDown = 8'(1 << KeyDown);
  localparam logic [7:0] BtnLeft = 8'(1 << KeyLeft);
  localparam logic [7:0] BtnRight = 8'(1 << KeyRight);

  // Semitone steps of the eight degrees, one row per mode, Ionian first.
  localparam logic [0:6][0:7][3:0] ScaleSteps = {
    32'h024579BC, 32'h023579AC, 32'h013578AC, 32'h024679BC,
    32'h024579AC, 32'h023578AC, 32'h013568AC
  };

  // Tone register codes, one row per note from C, one column per octave.
  localparam logic [0:11][0:6][10:0] NoteCodes = {
    {11'h02C, 11'h416, 11'h60B, 11'h706, 11'h782, 11'h7C1, 11'h7E0},
    {11'h09D, 11'h44E, 11'h627, 11'h714, 11'h789, 11'h7C4, 11'h7E2},
    {11'h107, 11'h483, 11'h642, 11'h721, 11'h790, 11'h7C8, 11'h7E4},
    {11'h16B, 11'h4B5, 11'h65B, 11'h72D, 11'h796, 11'h7CB, 11'h7E5},
    {11'h1CA, 11'h4E5, 11'h672, 11'h739, 11'h79C, 11'h7CE, 11'h7E7},
    {11'h223, 11'h511, 11'h689, 11'h744, 11'h7A2, 11'h7D1, 11'h7E8},
    {11'h277, 11'h53C, 11'h69E, 11'h74F, 11'h7A7, 11'h7D3, 11'h7E9},
    {11'h2C7, 11'h563, 11'h6B2, 11'h759, 11'h7AC, 11'h7D6, 11'h7EB},
    {11'h312, 11'h589, 11'h6C4, 11'h762, 11'h7B1, 11'h7D8, 11'h7EC},
    {11'h358, 11'h5AC, 11'h6D6, 11'h76B, 11'h7B5, 11'h7DA, 11'h7ED},
    {11'h39B, 11'h5CE, 11'h6E7, 11'h773, 11'h7B9, 11'h7DC, 11'h7EE},
    {11'h3DA, 11'h5ED, 11'h6F7, 11'h77B, 11'h7BD, 11'h7DE, 11'h7EF}
  };

  // One result item, laid out as on the master stream with note_start in bit 0.
  typedef struct packed {
    logic             pad;
    logic [ModeW-1:0] mode;
    logic [RootW-1:0] root;
    logic [OctW-1:0]  octave;
    logic [FreqW-1:0] freq;
    logic             stop;
    logic             start;
  } note_result_t;

  // Tracks the controller's musical state and the notes it should emit.
  class note_scoreboard;
    logic [KeyW-1:0]  held_keys;
    logic [OctW-1:0]  octave;
    logic [RootW-1:0] root;
    logic [ModeW-1:0] mode;
    logic [PosW-1:0]  position;
    logic             sounding;
    note_result_t     due_notes[$];
    int unsigned      errors;

    function new();
      held_keys = '0;
      octave = '0;
      root = RootReset;
      mode = ModeReset;
      position = '0;
      sounding = 1'b0;
      errors = 0;
    endfunction

    function int unsigned queued();
      return due_notes.size();
    endfunction

    // Tone code of a scale degree; a carry past the top octave is clamped.
    function logic [FreqW-1:0] degree_code(int unsigned degree);
      int unsigned semis;
      int unsigned oct;
      semis = int'(root) + int'(ScaleSteps[mode][3'(degree)]);
      oct = int'(octave) + semis / 12;
      if (oct > int'(OctaveTop)) oct = int'(OctaveTop);
      return NoteCodes[4'(semis % 12)][3'(oct)];
    endfunction

    // Applies one frame of button levels and queues the result item it causes.
    function void note_keys(logic [KeyW-1:0] keys);
      logic [KeyW-1:0] pressed;
      logic sel, st;
      note_result_t res;
      pressed = keys & ~held_keys;
      sel = keys[KeySelect];
      st = keys[KeyStart];
      res = '0;

      if (pressed[KeyUp] && octave < OctaveTop) octave = octave + 3'd1;
      else if (pressed[KeyDown] && octave != '0) octave = octave - 3'd1;

      if (st && !sel) begin
        if (pressed[KeyLeft]) root = 4'((int'(root) + 5) % 12);
        else if (pressed[KeyRight]) root = 4'((int'(root) + 7) % 12);
      end
      if (st && sel) begin
        if (pressed[KeyLeft]) root = 4'((int'(root) + 11) % 12);
        else if (pressed[KeyRight]) root = 4'((int'(root) + 1) % 12);
      end
      if (sel && !st) begin
        if (pressed[KeyLeft]) mode = 3'((int'(mode) + 6) % 7);
        else if (pressed[KeyRight]) mode = 3'((int'(mode) + 1) % 7);
      end

      if (!keys[KeyA] && !keys[KeyB] && sounding) begin
        sounding = 1'b0;
        res.stop = 1'b1;
      end
      if (!st && !sel) position = {keys[KeyRight], keys[KeyLeft]};

      // B takes the odd degree of the pair, A the even one; B wins.
      if (!sounding && (keys[KeyA] || keys[KeyB])) begin
        res.freq = degree_code(int'(position) * 2 + (keys[KeyB] ? 0 : 1));
        res.start = 1'b1;
        sounding = 1'b1;
      end

      held_keys = keys;
      res.octave = octave;
      res.root = root;
      res.mode = mode;
      due_notes.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      note_result_t got;
      note_result_t want;
      got = data;
      if (due_notes.size() == 0) begin
        $error("result item 0x%06h arrived with nothing expected", data);
        errors++;
        return;
      end
      want = due_notes.pop_front();
      compare_field("note_start", 32'(want.start), 32'(got.start));
      compare_field("note_stop", 32'(want.stop), 32'(got.stop));
      compare_field("freq_code", 32'(want.freq), 32'(got.freq));
      compare_field("octave_now", 32'(want.octave), 32'(got.octave));
      compare_field("root_now", 32'(want.root), 32'(got.root));
      compare_field("mode_now", 32'(want.mode), 32'(got.mode));
      compare_field("pad", 32'(want.pad), 32'(got.pad));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  note_scoreboard board = new();
  int unsigned    cycles = 0;
  // While calm is set neither side inserts random gaps; a requested hold-off still applies.
  bit             calm = 1'b0;
  // Asks the receiving side for one long hold-off.
  bit             hold_req = 1'b0;

  scale_degree_note_controller DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_span();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Frames that keep few keys down so that presses and releases are frequent.
  function automatic logic [7:0] random_keys();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 8'($urandom & $urandom & $urandom);
    if (roll < 75) return 8'($urandom & $urandom);
    if (roll < 90) return 8'h00;
    return 8'($urandom);
  endfunction

  task automatic idle_input(input int unsigned span);
    repeat (span) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
    end
  endtask

  task automatic offer_keys(input logic [7:0] keys);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= keys;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Both handshakes are sampled at the rising edge; the result is checked
  // before the new item is noted, as it always belongs to an older item.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    if (rst_ni && s_axis_tvalid && s_axis_tready) board.note_keys(s_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiving side: random stalls, plus one long hold-off on request.
  initial begin : result_drain
    int unsigned pause;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      pause = hold_req ? LongHold : idle_span();
      hold_req = 1'b0;
      if (pause != 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  initial begin : stimulus
    logic [7:0] opening[$];
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Opening sequence: down ignored at the bottom octave, trigger, hold,
    // release, B winning over A, octave climb with up winning over down,
    // a high degree clamped at the top octave, root moves by fifth and
    // semitone with left winning, mode moves with left winning, and every
    // key at once with up ignored at the top.
    opening = '{
      BtnDown, BtnA, BtnA, 8'h00, BtnA | BtnB, 8'h00,
      BtnUp, 8'h00, BtnUp | BtnDown, 8'h00, BtnUp, 8'h00, BtnUp, 8'h00, BtnUp,
      BtnA | BtnRight, 8'h00,
      BtnStart | BtnLeft, BtnStart | BtnRight, BtnStart | BtnSel,
      BtnStart | BtnSel | BtnLeft | BtnRight, BtnSel, BtnSel | BtnLeft | BtnRight,
      8'hFF, 8'h00
    };
    foreach (opening[i]) begin
      idle_input(idle_span());
      offer_keys(opening[i]);
    end

    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      // Midway the receiver stops for a long while; the sender keeps offering items without gaps.
      if (n == RandomItems / 2) begin
        calm = 1'b1;
        hold_req = 1'b1;
      end
      idle_input(idle_span());
      offer_keys(random_keys());
    end
    idle_input(1);

    while (board.queued() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
